// ----- hdl/mhpq_pkg.sv -----
package mhpq_pkg;

    // Operation codes carried on the input tuser bit.
    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_EMPTY      = 2'd2;

    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIFT_UP,
        S_PLACE,
        S_EXTRACT,
        S_SIFT_DOWN,
        S_RESULT
    } mhpq_state_t;

endpackage

// ----- hdl/mhpq_ram.sv -----
module mhpq_ram
    import mhpq_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and two read ports; read data is registered.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- hdl/max_heap_priority_queue.sv -----
// Channel | Ports                            | Contents (lowest bit first)
// --------+----------------------------------+-------------------------------------------
// input   | s_axis_tvalid/tready/tdata/tuser | tdata: item_value[31:0]; tuser: op
// result  | m_axis_tvalid/tready/tdata       | tdata: max_value[31:0], status[33:32],
//         |                                  |        entry_count[40:34], zeros to [47:41]
//
// One item is in the engine at a time; s_axis_tready is high only while the engine is idle.
// A rejected operation goes straight to its result register; an insert sifts up and an extract
// sifts down one tree level per step, each step working on the registered memory read data.
// Reset (aresetn low, synchronous) empties the heap and drops any pending result; the memory
// contents are not cleared. A finished result waits in the output register while the next item
// is worked on; the engine stalls before handing over while that register is still full.
module max_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // item_value[31:0]
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // max_value, status, entry_count, zero pad
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    mhpq_state_t state_reg, state_next;

    logic [CW-1:0]            count_reg, count_next;
    logic [AW-1:0]            pos_reg, pos_next;
    logic signed [VALUE_W-1:0] hold_reg, hold_next;    // value being sifted
    logic [VALUE_W-1:0]       res_val_reg, res_val_next;
    logic [STATUS_W-1:0]      res_st_reg, res_st_next;

    logic                     m_valid_reg;
    logic [VALUE_W-1:0]       m_val_reg;
    logic [STATUS_W-1:0]      m_st_reg;
    logic [COUNT_W-1:0]       m_cnt_reg;

    // Memory port signals.
    logic                     we;
    logic [AW-1:0]            waddr;
    logic [VALUE_W-1:0]       wdata;
    logic [AW-1:0]            raddr_a, raddr_b;
    logic [VALUE_W-1:0]       rdata_a, rdata_b;

    logic                     accept;
    logic [AW-1:0]            pos_dec, parent_pos, count_pos, count_dec_pos, insert_parent;
    logic [IW-1:0]            left_idx, right_idx, cnt_ext, child_idx;
    logic                     left_ok, right_ok, take_left, take_right;
    logic signed [VALUE_W-1:0] best_val;
    logic [AW-1:0]            best_pos;
    logic [CW+COUNT_W-1:0]    cnt_wide;

    mhpq_ram #(
        .DEPTH(CAPACITY),
        .WIDTH(VALUE_W)
    ) u_ram (
        .aclk    (aclk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Parent of the current position and of the slot a new insert lands in.
    assign pos_dec       = pos_reg - AW'(1);
    assign parent_pos    = AW'(pos_dec >> 1);
    assign count_pos     = count_reg[AW-1:0];
    assign count_dec_pos = count_pos - AW'(1);
    assign insert_parent = AW'(count_dec_pos >> 1);

    // Child selection during sift down. The left child wins a tie.
    assign left_idx  = {1'b0, pos_reg, 1'b1};
    assign right_idx = left_idx + IW'(1);
    assign cnt_ext   = IW'(count_reg);
    assign left_ok   = (left_idx < cnt_ext);
    assign right_ok  = (right_idx < cnt_ext);

    always_comb begin
        take_left  = left_ok && (hold_reg < $signed(rdata_a));
        best_val   = take_left ? $signed(rdata_a) : hold_reg;
        take_right = right_ok && (best_val < $signed(rdata_b));
        best_pos   = take_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
    end

    // Left child of the position the sift moves on to.
    assign child_idx = {1'b0, best_pos, 1'b1};

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        hold_next    = hold_reg;
        res_val_next = res_val_reg;
        res_st_next  = res_st_reg;
        we           = 1'b0;
        waddr        = pos_reg;
        wdata        = hold_reg;
        raddr_a      = parent_pos;
        raddr_b      = parent_pos;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_val_next = '0;
                    res_st_next  = ST_DONE;
                    if (s_axis_tuser == OP_INSERT) begin
                        if (count_reg == CW'(CAPACITY)) begin
                            res_st_next = ST_FULL;
                            state_next  = S_RESULT;
                        end else begin
                            count_next = count_reg + CW'(1);
                            pos_next   = count_pos;
                            hold_next  = $signed(s_axis_tdata);
                            if (count_reg == '0) begin
                                // First entry goes straight to the root.
                                we         = 1'b1;
                                waddr      = '0;
                                wdata      = s_axis_tdata;
                                state_next = S_RESULT;
                            end else begin
                                raddr_a    = insert_parent;
                                state_next = S_SIFT_UP;
                            end
                        end
                    end else begin
                        if (count_reg == '0) begin
                            res_st_next = ST_EMPTY;
                            state_next  = S_RESULT;
                        end else begin
                            count_next = count_reg - CW'(1);
                            raddr_a    = '0;
                            raddr_b    = count_dec_pos;
                            state_next = S_EXTRACT;
                        end
                    end
                end
            end

            S_SIFT_UP: begin
                we = 1'b1;
                if (hold_reg > $signed(rdata_a)) begin
                    // Parent moves down into the hole.
                    wdata    = rdata_a;
                    pos_next = parent_pos;
                    if (parent_pos == '0) begin
                        state_next = S_PLACE;
                    end else begin
                        raddr_a = AW'((parent_pos - AW'(1)) >> 1);
                    end
                end else begin
                    state_next = S_RESULT;
                end
            end

            S_PLACE: begin
                we         = 1'b1;
                state_next = S_RESULT;
            end

            S_EXTRACT: begin
                res_val_next = rdata_a;
                hold_next    = $signed(rdata_b);
                pos_next     = '0;
                if (count_reg == '0) begin
                    state_next = S_RESULT;
                end else begin
                    raddr_a    = AW'(1);
                    raddr_b    = AW'(2 % CAPACITY);
                    state_next = S_SIFT_DOWN;
                end
            end

            S_SIFT_DOWN: begin
                we = 1'b1;
                if (take_left || take_right) begin
                    // Larger child moves up into the hole.
                    wdata      = best_val;
                    if (take_right) begin
                        wdata = rdata_b;
                    end
                    pos_next   = best_pos;
                    raddr_a    = child_idx[AW-1:0];
                    raddr_b    = child_idx[AW-1:0] + AW'(1);
                end else begin
                    state_next = S_RESULT;
                end
            end

            S_RESULT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg     <= pos_next;
        hold_reg    <= hold_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
    end

    assign cnt_wide = {{COUNT_W{1'b0}}, count_reg};

    // Output register; loaded when the engine hands over a finished result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_RESULT && (!m_valid_reg || m_axis_tready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_RESULT && (!m_valid_reg || m_axis_tready)) begin
            m_val_reg <= res_val_reg;
            m_st_reg  <= res_st_reg;
            m_cnt_reg <= cnt_wide[COUNT_W-1:0];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'b0, m_cnt_reg, m_st_reg, m_val_reg};

endmodule
